>>> design/bmv_pkg.sv
// ============================================================================
// bmv_pkg
// Shared constants and types for the bf16 matrix-vector product unit.
// ============================================================================
package bmv_pkg;

    localparam int ROWS        = 32;
    localparam int MAX_COLUMNS = 1024;
    localparam int LANES       = 32;
    localparam int BANKS       = 4;

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int LEN_W   = COL_W + 1;
    localparam int LANE_W  = $clog2(LANES);
    localparam int BANK_W  = $clog2(BANKS);
    localparam int ACC_AW  = LANE_W + BANK_W;
    localparam int ROW_W   = 5;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(896);
    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(LANES);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_COLUMNS);

    localparam logic OP_ACT    = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    typedef enum logic [1:0] {
        FPU_ADD = 2'b01,
        FPU_MUL = 2'b10
    } fpu_op_t;

endpackage

>>> design/bf16_matrix_vector_product_unit.sv
// ============================================================================
// bf16_matrix_vector_product_unit
// Stores a bf16 activation vector, accumulates weight*activation products in
// 4 banks of 32 fp32 lanes, and emits one bf16 dot product per matrix row.
// ============================================================================
// Activation items are taken whenever the unit is idle. A weight item is read,
// multiplied, added and written back through one shared fp unit, with s_tready low
// until it is done. Row end sums the 4 banks of each of the 32 lanes, and the lanes
// into the row sum, on the same unit; m_tvalid then rises if the output is free.
// Reset: row counter 0, row length 896, all accumulators read as +0;
// activation store is undefined until written.
module bf16_matrix_vector_product_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [9:0] column, [25:10] value, rest zero
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [4:0] row_index, [20:5] result, rest zero
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata  // columns_in_use
);
    import bmv_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MUL  = 10'b0000000010,
        S_ADD  = 10'b0000000100,
        S_WB   = 10'b0000001000,
        S_RRD  = 10'b0000010000,
        S_RGET = 10'b0000100000,
        S_RT   = 10'b0001000000,
        S_SUM  = 10'b0010000000,
        S_SUMW = 10'b0100000000,
        S_EMIT = 10'b1000000000
    } state_t;

    state_t                state_reg, state_next;
    logic [LEN_W-1:0]      cols_reg;
    logic [LEN_W-1:0]      len;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [15:0]           w_reg, w_next;
    logic [31:0]           acc_reg, acc_next;
    logic [31:0]           t_reg, t_next;
    logic [31:0]           sum_reg, sum_next;
    logic [BANK_W-1:0]     bk_reg, bk_next;
    logic [LANE_W-1:0]     lane_reg, lane_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [BANKS*LANES-1:0] vld_reg, vld_next;
    logic                  mv_reg, mv_next;
    logic [ROW_W-1:0]      orow_reg, orow_next;
    logic [15:0]           ores_reg, ores_next;
    logic                  olast_reg, olast_next;

    logic [15:0]           act_mem [MAX_COLUMNS];
    logic [15:0]           act_q;
    logic [31:0]           acc_mem [BANKS*LANES];
    logic [31:0]           acc_q;
    logic [ACC_AW-1:0]     rd_addr;
    logic [ACC_AW-1:0]     rd_addr_q;
    logic                  acc_we;

    logic                  in_acc;
    logic                  in_op;
    logic [COL_W-1:0]      in_col;
    logic [15:0]           in_val;
    logic                  out_free;
    logic [31:0]           bank_val;
    logic [31:0]           rnd;

    fpu_op_t               fop;
    logic [31:0]           fa;
    logic [31:0]           fb;
    logic [31:0]           fq;

    assign in_op  = s_tuser[0];
    assign in_col = s_tdata[COL_W-1:0];
    assign in_val = s_tdata[COL_W+15:COL_W];
    assign in_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !mv_reg || m_tready;

    // clamp the row length
    always_comb
    begin
        if (cols_reg < LEN_MIN) begin
            len = LEN_MIN;
        end
        else if (cols_reg > LEN_MAX) begin
            len = LEN_MAX;
        end
        else begin
            len = cols_reg;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cols_reg <= LEN_RESET;
        end
        else if (cfg_we) begin
            cols_reg <= cfg_wdata;
        end
    end

    // activation store: write on activation items, read on accept
    always_ff @(posedge clk)
    begin
        if (in_acc && (in_op == OP_ACT)) begin
            act_mem[in_col] <= in_val;
        end
        act_q <= act_mem[in_col];
    end

    // accumulator banks: one read, one write port
    assign rd_addr = (state_reg == S_IDLE) ? in_col[ACC_AW-1:0] : {bk_reg, lane_reg};
    assign acc_we  = (state_reg == S_WB);

    always_ff @(posedge clk)
    begin
        if (acc_we) begin
            acc_mem[col_reg[ACC_AW-1:0]] <= fq;
        end
        acc_q     <= acc_mem[rd_addr];
        rd_addr_q <= rd_addr;
    end

    // entries not written since the row began read as +0
    assign bank_val = vld_reg[rd_addr_q] ? acc_q : 32'd0;

    // fp unit operand select
    always_comb
    begin
        fop = FPU_ADD;
        fa  = t_reg;
        fb  = bank_val;
        case (state_reg)
            S_MUL:
            begin
                fop = FPU_MUL;
                fa  = {16'd0, w_reg};
                fb  = {16'd0, act_q};
            end
            S_ADD:
            begin
                fa = acc_reg;
                fb = fq;
            end
            S_SUM:
            begin
                fa = sum_reg;
                fb = t_reg;
            end
            default:
            begin
                fa = t_reg;
                fb = bank_val;
            end
        endcase
    end

    bmv_fpu u_fpu (
        .clk (clk),
        .op  (fop),
        .a   (fa),
        .b   (fb),
        .q   (fq)
    );

    // bf16 rounding of the row sum; NaN keeps its top half, made quiet
    always_comb
    begin
        if ((sum_reg[30:0] > 31'h7F80_0000)) begin
            rnd = {sum_reg[31:16] | 16'h0040, 16'd0};
        end
        else begin
            rnd = sum_reg + 32'h0000_7FFF + {31'd0, sum_reg[16]};
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        w_next     = w_reg;
        acc_next   = acc_reg;
        t_next     = t_reg;
        sum_next   = sum_reg;
        bk_next    = bk_reg;
        lane_next  = lane_reg;
        row_next   = row_reg;
        vld_next   = vld_reg;
        mv_next    = mv_reg && !m_tready;
        orow_next  = orow_reg;
        ores_next  = ores_reg;
        olast_next = olast_reg;
        case (state_reg)
            S_IDLE:
            begin
                // take a weight inside the row
                if (in_acc && (in_op == OP_WEIGHT) && ({1'b0, in_col} < len)) begin
                    col_next   = in_col;
                    w_next     = in_val;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next   = bank_val;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                vld_next[col_reg[ACC_AW-1:0]] = 1'b1;
                if ({1'b0, col_reg} == (len - LEN_W'(1))) begin
                    bk_next    = '0;
                    lane_next  = '0;
                    state_next = S_RRD;
                end
                else begin
                    state_next = S_IDLE;
                end
            end
            S_RRD:
            begin
                state_next = S_RGET;
            end
            S_RGET:
            begin
                // first bank loads the partial, others add into it
                if (bk_reg == '0) begin
                    t_next     = bank_val;
                    bk_next    = bk_reg + BANK_W'(1);
                    state_next = S_RRD;
                end
                else begin
                    state_next = S_RT;
                end
            end
            S_RT:
            begin
                t_next = fq;
                if (bk_reg == BANK_W'(BANKS - 1)) begin
                    state_next = S_SUM;
                end
                else begin
                    bk_next    = bk_reg + BANK_W'(1);
                    state_next = S_RRD;
                end
            end
            S_SUM:
            begin
                state_next = S_SUMW;
            end
            S_SUMW:
            begin
                sum_next = fq;
                if (lane_reg == LANE_W'(LANES - 1)) begin
                    state_next = S_EMIT;
                end
                else begin
                    lane_next  = lane_reg + LANE_W'(1);
                    bk_next    = '0;
                    state_next = S_RRD;
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (out_free) begin
                    mv_next    = 1'b1;
                    orow_next  = row_reg;
                    ores_next  = rnd[31:16];
                    olast_next = (row_reg == ROW_W'(ROWS - 1));
                    row_next   = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + ROW_W'(1);
                    vld_next   = '0;
                    sum_next   = 32'd0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            vld_reg   <= '0;
            mv_reg    <= 1'b0;
            sum_reg   <= 32'd0;
            bk_reg    <= '0;
            lane_reg  <= '0;
        end
        else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            vld_reg   <= vld_next;
            mv_reg    <= mv_next;
            sum_reg   <= sum_next;
            bk_reg    <= bk_next;
            lane_reg  <= lane_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        w_reg     <= w_next;
        acc_reg   <= acc_next;
        t_reg     <= t_next;
        orow_reg  <= orow_next;
        ores_reg  <= ores_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {3'd0, ores_reg, orow_reg};
    assign m_tlast  = olast_reg;

endmodule

>>> design/bmv_fpu.sv
// ============================================================================
// bmv_fpu
// Shared floating-point unit: bf16 x bf16 -> fp32 multiply, or fp32 + fp32
// add, both IEEE round-to-nearest-even. Result registered.
// ============================================================================
module bmv_fpu (
    input  logic            clk,
    input  bmv_pkg::fpu_op_t op,
    input  logic [31:0]     a,
    input  logic [31:0]     b,
    output logic [31:0]     q
);
    import bmv_pkg::*;

    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

    // fp32 add with guard, round and sticky bits
    function automatic logic [31:0] fp_add(logic [31:0] fa, logic [31:0] fb);
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [23:0] mx;
        logic [23:0] my;
        logic [7:0]  d;
        logic [26:0] sm;
        logic [26:0] sy27;
        logic        st;
        logic [27:0] s;
        logic [9:0]  e;
        logic [4:0]  lz;
        logic [9:0]  sh;
        logic        up;
        logic [30:0] r;
        logic        nan_a;
        logic        nan_b;
        logic        inf_a;
        logic        inf_b;
        nan_a = (fa[30:23] == 8'hFF) && (fa[22:0] != 23'd0);
        nan_b = (fb[30:23] == 8'hFF) && (fb[22:0] != 23'd0);
        inf_a = (fa[30:23] == 8'hFF) && (fa[22:0] == 23'd0);
        inf_b = (fb[30:23] == 8'hFF) && (fb[22:0] == 23'd0);
        if (nan_a) begin
            return fa | QUIET_BIT;
        end
        if (nan_b) begin
            return fb | QUIET_BIT;
        end
        if (inf_a && inf_b && (fa[31] != fb[31])) begin
            return QNAN_DEFAULT;
        end
        if (inf_a) begin
            return fa;
        end
        if (inf_b) begin
            return fb;
        end
        // larger magnitude first
        if (fb[30:0] > fa[30:0]) begin
            x = fb;
            y = fa;
        end
        else begin
            x = fa;
            y = fb;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx = {x[30:23] != 8'd0, x[22:0]};
        my = {y[30:23] != 8'd0, y[22:0]};
        d  = ex - ey;
        sy27 = {my, 3'b000};
        // align the smaller operand, fold lost bits into sticky
        if (d >= 8'd27) begin
            sm = 27'd0;
            st = (my != 24'd0);
        end
        else begin
            st = |(sy27 & ((27'd1 << d[4:0]) - 27'd1));
            sm = sy27 >> d[4:0];
        end
        sm[0] = sm[0] | st;
        if (x[31] ^ y[31]) begin
            s = {1'b0, mx, 3'b000} - {1'b0, sm};
        end
        else begin
            s = {1'b0, mx, 3'b000} + {1'b0, sm};
        end
        if (s == 28'd0) begin
            return {x[31] & y[31], 31'd0};
        end
        e = {2'b00, ex};
        // normalize
        if (s[27]) begin
            s = {1'b0, s[27:2], s[1] | s[0]};
            e = e + 10'd1;
        end
        else begin
            lz = 5'd27;
            for (int i = 0; i < 27; i++) begin
                if (s[i]) begin
                    lz = 5'(26 - i);
                end
            end
            sh = ({5'd0, lz} < (e - 10'd1)) ? {5'd0, lz} : (e - 10'd1);
            s  = s << sh;
            e  = e - sh;
            if (!s[26]) begin
                e = 10'd0;
            end
        end
        if (e >= 10'd255) begin
            return {x[31], 8'hFF, 23'd0};
        end
        up = s[2] & (s[1] | s[0] | s[3]);
        r  = {e[7:0], s[25:3]} + {30'd0, up};
        return {x[31], r};
    endfunction

    // exact bf16 product, rounded into fp32 only when subnormal
    function automatic logic [31:0] bf_mul(logic [15:0] w, logic [15:0] v);
        logic               sg;
        logic               nan_w;
        logic               nan_v;
        logic               inf_w;
        logic               inf_v;
        logic               zero_w;
        logic               zero_v;
        logic [7:0]         ew;
        logic [7:0]         ev;
        logic [15:0]        p;
        logic [15:0]        pn;
        logic [3:0]         lz;
        logic signed [11:0] ep;
        logic signed [11:0] sh;
        logic [26:0]        sig;
        logic               st;
        logic               up;
        logic [30:0]        r;
        sg     = w[15] ^ v[15];
        nan_w  = (w[14:7] == 8'hFF) && (w[6:0] != 7'd0);
        nan_v  = (v[14:7] == 8'hFF) && (v[6:0] != 7'd0);
        inf_w  = (w[14:7] == 8'hFF) && (w[6:0] == 7'd0);
        inf_v  = (v[14:7] == 8'hFF) && (v[6:0] == 7'd0);
        zero_w = (w[14:0] == 15'd0);
        zero_v = (v[14:0] == 15'd0);
        if (nan_w) begin
            return {w, 16'd0} | QUIET_BIT;
        end
        if (nan_v) begin
            return {v, 16'd0} | QUIET_BIT;
        end
        if ((inf_w && zero_v) || (zero_w && inf_v)) begin
            return QNAN_DEFAULT;
        end
        if (inf_w || inf_v) begin
            return {sg, 8'hFF, 23'd0};
        end
        if (zero_w || zero_v) begin
            return {sg, 31'd0};
        end
        ew = (w[14:7] == 8'd0) ? 8'd1 : w[14:7];
        ev = (v[14:7] == 8'd0) ? 8'd1 : v[14:7];
        p  = {8'd0, w[14:7] != 8'd0, w[6:0]} * {8'd0, v[14:7] != 8'd0, v[6:0]};
        lz = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (p[i]) begin
                lz = 4'(15 - i);
            end
        end
        pn = p << lz;
        ep = $signed({4'd0, ew}) + $signed({4'd0, ev}) - 12'sd126 - $signed({8'd0, lz});
        if (ep >= 12'sd255) begin
            return {sg, 8'hFF, 23'd0};
        end
        if (ep >= 12'sd1) begin
            return {sg, ep[7:0], pn[14:0], 8'd0};
        end
        // subnormal result: shift right with sticky and round
        sh  = 12'sd1 - ep;
        sig = {pn, 11'd0};
        if (sh >= 12'sd27) begin
            sig = 27'd0;
            st  = 1'b1;
        end
        else begin
            st  = |(sig & ((27'd1 << sh[4:0]) - 27'd1));
            sig = sig >> sh[4:0];
        end
        sig[0] = sig[0] | st;
        up = sig[2] & (sig[1] | sig[0] | sig[3]);
        r  = {8'd0, sig[25:3]} + {30'd0, up};
        return {sg, r};
    endfunction

    // compute and register
    always_ff @(posedge clk)
    begin
        case (op)
            FPU_MUL: q <= bf_mul(a[15:0], b[15:0]);
            FPU_ADD: q <= fp_add(a, b);
            default: q <= fp_add(a, b);
        endcase
    end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: bf16 matrix-vector product unit
// Loads activation vectors and streams weight rows with random gaps, register
// changes and noise items. A scoreboard class predicts each row's bf16 dot
// product in bit-exact fp32 arithmetic and checks every output item in order.
// ----------------------------------------------------------------------------
module testbench;
    import bmv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 20;
    localparam int ACT_FILL    = 256;

    localparam logic [15:0] BF_ONE     = 16'h3F80;
    localparam logic [31:0] F32_INF    = 32'h7F800000;
    localparam logic [31:0] F32_DEFNAN = 32'hFFC00000;

    // ------------------------------------------------------------------------
    // Dot product predictor and checker
    // ------------------------------------------------------------------------
    class dot_product_scoreboard;
        typedef struct {
            logic [4:0]  row;
            logic [15:0] dot;
            logic        last;
        } row_result_t;

        logic [15:0]   act_mem [MAX_COLUMNS];
        logic [31:0]   bank_sum [BANKS][LANES];
        int unsigned   row_count;
        logic [10:0]   length_reg;
        row_result_t   rows_due [$];
        int            errors;

        function new();
            length_reg = LEN_RESET;
            row_count  = 0;
            errors     = 0;
            clear_banks();
        endfunction

        function void clear_banks();
            foreach (bank_sum[b, l])
                bank_sum[b][l] = 32'h0;
        endfunction

        static function bit is_nan(logic [31:0] f);
            return (f[30:23] == 8'hFF) && (f[22:0] != 0);
        endfunction

        // Exact value of an fp32 pattern as a double
        static function real f32_value(logic [31:0] f);
            real v;
            if (f[30:23] == 8'hFF)
                return $bitstoreal({f[31], 11'h7FF, 52'h0});
            if (f[30:23] == 8'h00)
            begin
                v = real'(f[22:0]) * (2.0 ** (-149));
                return f[31] ? -v : v;
            end
            return $bitstoreal({f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'h0});
        endfunction

        // Round a double to fp32, nearest-even, with subnormals and overflow
        static function logic [31:0] round_f32(real r);
            logic [63:0] d, m53, rem, half, keep, val;
            int          e, sh;
            d = $realtobits(r);
            if (d[62:52] == 11'h7FF)
                return {d[63], F32_INF[30:0]};
            if (d[62:52] == 11'h000)
                return {d[63], 31'h0};
            e = int'(d[62:52]) - 1023;
            if (e > 127)
                return {d[63], F32_INF[30:0]};
            m53 = {11'h0, 1'b1, d[51:0]};
            sh  = (e >= -126) ? 29 : 29 + (-126 - e);
            if (sh > 54)
                return {d[63], 31'h0};
            keep = m53 >> sh;
            rem  = m53 & ((64'h1 << sh) - 1);
            half = 64'h1 << (sh - 1);
            if (e >= -126)
                val = (64'(e + 127) << 23) + (keep & 64'h7FFFFF);
            else
                val = keep;
            if (rem > half || (rem == half && keep[0]))
                val = val + 1;
            if (val >= 64'(F32_INF))
                val = 64'(F32_INF);
            return {d[63], val[30:0]};
        endfunction

        static function logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
            if (is_nan(a))
                return a | 32'h00400000;
            if (is_nan(b))
                return b | 32'h00400000;
            // opposite infinities
            if (a[30:0] == F32_INF[30:0] && b[30:0] == F32_INF[30:0] && a[31] != b[31])
                return F32_DEFNAN;
            return round_f32(f32_value(a) + f32_value(b));
        endfunction

        static function logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
            if (is_nan(a))
                return a | 32'h00400000;
            if (is_nan(b))
                return b | 32'h00400000;
            // zero times infinity
            if ((a[30:0] == 0 && b[30:0] == F32_INF[30:0]) ||
                (b[30:0] == 0 && a[30:0] == F32_INF[30:0]))
                return F32_DEFNAN;
            return round_f32(f32_value(a) * f32_value(b));
        endfunction

        static function logic [15:0] to_bf16(logic [31:0] f);
            logic [31:0] u;
            if (f[30:0] > F32_INF[30:0])
                return f[31:16] | 16'h0040;
            u = f + 32'h7FFF + 32'(f[16]);
            return u[31:16];
        endfunction

        function int unsigned row_length();
            if (length_reg < LEN_MIN)
                return LANES;
            if (length_reg > LEN_MAX)
                return MAX_COLUMNS;
            return length_reg;
        endfunction

        // Run one accepted input item through the model of the datapath
        function void note_input(logic op, logic [9:0] col, logic [15:0] val);
            int unsigned len;
            logic [31:0] prod, part, sum;
            row_result_t rr;
            if (op == OP_ACT)
            begin
                act_mem[col] = val;
                return;
            end
            len = row_length();
            if (col >= len)
                return;
            prod = f32_mul({val, 16'h0}, {act_mem[col], 16'h0});
            bank_sum[col[6:5]][col[4:0]] = f32_add(bank_sum[col[6:5]][col[4:0]], prod);
            if (col != len - 1)
                return;
            sum = 32'h0;
            for (int l = 0; l < LANES; l++)
            begin
                part = f32_add(bank_sum[0][l], bank_sum[1][l]);
                part = f32_add(part, bank_sum[2][l]);
                part = f32_add(part, bank_sum[3][l]);
                sum  = f32_add(sum, part);
            end
            rr.row  = row_count[4:0];
            rr.dot  = to_bf16(sum);
            rr.last = (row_count >= ROWS - 1);
            rows_due.push_back(rr);
            row_count = rr.last ? 0 : row_count + 1;
            clear_banks();
        endfunction

        // Compare one output item with the oldest predicted row
        function void check(logic [23:0] data, logic tlast);
            row_result_t rr;
            if (rows_due.size() == 0)
            begin
                $display("%0t: unexpected output item, expected none, actual row %0d dot %h",
                         $time, data[4:0], data[20:5]);
                errors++;
                return;
            end
            rr = rows_due.pop_front();
            if (data[4:0] !== rr.row)
            begin
                $display("%0t: row_index expected %0d actual %0d", $time, rr.row, data[4:0]);
                errors++;
            end
            if (data[20:5] !== rr.dot)
            begin
                $display("%0t: row %0d result expected %h actual %h",
                         $time, rr.row, rr.dot, data[20:5]);
                errors++;
            end
            if (tlast !== rr.last)
            begin
                $display("%0t: row %0d last expected %b actual %b",
                         $time, rr.row, rr.last, tlast);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [10:0] cfg_wdata;

    dot_product_scoreboard sb;
    bit                    calm;
    int                    cycles;

    bf16_matrix_vector_product_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Check each accepted output item
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check(m_tdata, m_tlast);
    end

    // Random back-pressure on the output side
    initial
    begin
        int stall;
        int r;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                r = $urandom_range(0, 99);
                if (!calm && r < 12)
                    stall = (r < 9) ? $urandom_range(1, 3) : $urandom_range(20, 400);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(15, 150);
    endfunction

    // Mostly moderate magnitudes, sometimes any pattern at all
    function automatic logic [15:0] rand_bf16();
        if ($urandom_range(0, 99) < 85)
            return {1'($urandom), 8'($urandom_range(118, 134)), 7'($urandom)};
        return 16'($urandom);
    endfunction

    // Offer one item; hold valid high across back-to-back items
    task automatic send_item(logic op, logic [9:0] col, logic [15:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'h0, val, col};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(op, col, val);
    endtask

    // Drop valid and hold until every predicted row has left
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.rows_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_length(logic [10:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.length_reg = v;
    endtask

    // One row in order, with noise: activation rewrites, out-of-row weights
    // and the odd skipped column
    task automatic send_row();
        int unsigned len;
        int          r;
        len = sb.row_length();
        for (int c = 0; c < len; c++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_item(OP_ACT, 10'($urandom), rand_bf16());
            else if (r < 6 && len < MAX_COLUMNS)
                send_item(OP_WEIGHT, 10'($urandom_range(len, MAX_COLUMNS - 1)), rand_bf16());
            if (r >= 6 && r < 8 && c != len - 1)
                continue;
            send_item(OP_WEIGHT, 10'(c), rand_bf16());
        end
    endtask

    initial
    begin
        logic [15:0] dir_act [8];
        logic [15:0] dir_wt [8];
        int          n;
        dir_act = '{16'h7F7F, 16'h7F80, 16'hFF80, 16'h0080, 16'h8000, 16'h7FC1, 16'h0001, 16'hFFFF};
        dir_wt  = '{16'h7F7F, 16'h3F80, 16'h3F80, 16'h0080, 16'h7F80, 16'h3F80, 16'hFF7F, 16'h0000};

        sb        = new();
        calm      = 1'b0;
        cycles    = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Exercise every register bit, then settle on the shortest row
        write_length(11'h7FF);
        write_length(11'd32);

        // Fill every activation entry the rows below read
        for (int c = 0; c < ACT_FILL; c++)
            send_item(OP_ACT, 10'(c), rand_bf16());

        // Special values: overflow, infinities, NaN, subnormals, signed zero
        for (int c = 0; c < 8; c++)
            send_item(OP_ACT, 10'(c), dir_act[c]);
        for (int c = 0; c < 32; c++)
            send_item(OP_WEIGHT, 10'(c), (c < 8) ? dir_wt[c] : BF_ONE);
        drain();
        for (int c = 0; c < 8; c++)
            send_item(OP_ACT, 10'(c), rand_bf16());

        // Length below the minimum clamps to 32; no idling here
        calm = 1'b1;
        drain();
        write_length(11'd0);
        repeat (4) send_row();
        calm = 1'b0;

        // Length off the lane grid
        drain();
        write_length(11'd47);
        repeat (2) send_row();

        // Long row: the bank index runs through all four banks twice
        drain();
        write_length(11'(ACT_FILL));
        send_row();

        // Random lengths, mostly short
        for (int p = 0; p < 8; p++)
        begin
            drain();
            n = $urandom_range(32, 80);
            write_length(11'(n));
            repeat (2) send_row();
        end

        drain();
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
design/bmv_pkg.sv
design/bmv_fpu.sv
design/bf16_matrix_vector_product_unit.sv
dv/testbench.sv
